// ----- rtl/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared constants and types for the websocket frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int OPCODE_W = 4;
  localparam int LEN_W    = 16;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

  localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd4096;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                final_flag;
    logic                last;
  } result_t;

endpackage

// ----- rtl/wsfr_parser.sv -----
// ----------------------------------------------------------------------------
// wsfr_parser
// Header state machine and payload unmasking, one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module wsfr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [wsfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [wsfr_pkg::LEN_W-1:0]  max_payload,
  output logic                        res_valid,
  output wsfr_pkg::result_t           res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAY,
    PH_STOP
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [wsfr_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic                          fin_r, fin_nxt;
  logic                          mask_on_r, mask_on_nxt;
  logic [2:0]                    ext_r, ext_nxt;
  logic [wsfr_pkg::LEN_W-1:0]    len_r, len_nxt;
  // set when any length bit above the low 16 is nonzero
  logic                          len_hi_r, len_hi_nxt;
  logic [31:0]                   key_r, key_nxt;
  logic [wsfr_pkg::LEN_W-1:0]    idx_r, idx_nxt;

  logic                          len_done;
  logic                          hdr_done;
  logic [wsfr_pkg::BYTE_W-1:0]   key_byte;
  logic [wsfr_pkg::LEN_W:0]      idx_plus1;
  logic                          pay_last;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign idx_plus1 = {1'b0, idx_r} + {{wsfr_pkg::LEN_W{1'b0}}, 1'b1};
  assign pay_last  = (idx_plus1 >= {1'b0, len_r});

  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    fin_nxt     = fin_r;
    mask_on_nxt = mask_on_r;
    ext_nxt     = ext_r;
    len_nxt     = len_r;
    len_hi_nxt  = len_hi_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    res_valid   = 1'b0;
    res.kind         = wsfr_pkg::KIND_DATA;
    res.data         = '0;
    res.frame_opcode = op_r;
    res.final_flag   = fin_r;
    res.last         = 1'b0;

    case (phase_r)
      PH_HDR0: begin
        fin_nxt     = rx_byte[7];
        op_nxt      = rx_byte[3:0];
        mask_on_nxt = 1'b0;
        key_nxt     = '0;
        len_nxt     = '0;
        len_hi_nxt  = 1'b0;
        ext_nxt     = '0;
        idx_nxt     = '0;
        phase_nxt   = PH_HDR1;
      end
      PH_HDR1: begin
        if (op_r == wsfr_pkg::OP_CLOSE) begin
          phase_nxt = PH_STOP;
          res_valid = 1'b1;
          res.kind  = wsfr_pkg::KIND_CLOSE;
          res.last  = 1'b1;
        end else begin
          mask_on_nxt = rx_byte[7];
          if (rx_byte[6:0] == wsfr_pkg::LEN_CODE_EXT16) begin
            ext_nxt   = 3'd1;
            phase_nxt = PH_EXT;
          end else if (rx_byte[6:0] == wsfr_pkg::LEN_CODE_EXT64) begin
            ext_nxt   = 3'd7;
            phase_nxt = PH_EXT;
          end else begin
            len_nxt  = {{(wsfr_pkg::LEN_W-7){1'b0}}, rx_byte[6:0]};
            len_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        // big-endian shift; bytes leaving the low 16 bits feed the sticky flag
        len_nxt    = {len_r[7:0], rx_byte};
        len_hi_nxt = len_hi_r | (len_r[15:8] != 8'd0);
        if (ext_r == 3'd0) begin
          len_done = 1'b1;
        end else begin
          ext_nxt = ext_r - 3'd1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        idx_nxt = idx_r + {{(wsfr_pkg::LEN_W-1){1'b0}}, 1'b1};
        if (idx_r[1:0] == 2'd3) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAY: begin
        idx_nxt   = idx_r + {{(wsfr_pkg::LEN_W-1){1'b0}}, 1'b1};
        res_valid = 1'b1;
        res.kind  = wsfr_pkg::KIND_DATA;
        res.data  = rx_byte ^ key_byte;
        res.last  = pay_last;
        if (pay_last) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_STOP: begin
        phase_nxt = PH_STOP;
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    if (len_done) begin
      if (mask_on_nxt) begin
        idx_nxt   = '0;
        phase_nxt = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      if (len_hi_nxt || (len_nxt > max_payload)) begin
        phase_nxt = PH_STOP;
        res_valid = 1'b1;
        res.kind  = wsfr_pkg::KIND_ERROR;
        res.last  = 1'b1;
      end else if (len_nxt == '0) begin
        phase_nxt = PH_HDR0;
        res_valid = 1'b1;
        res.kind  = wsfr_pkg::KIND_EMPTY;
        res.last  = 1'b1;
      end else begin
        idx_nxt   = '0;
        phase_nxt = PH_PAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      op_r      <= '0;
      fin_r     <= 1'b0;
      mask_on_r <= 1'b0;
      ext_r     <= '0;
      len_r     <= '0;
      len_hi_r  <= 1'b0;
      key_r     <= '0;
      idx_r     <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      op_r      <= op_nxt;
      fin_r     <= fin_nxt;
      mask_on_r <= mask_on_nxt;
      ext_r     <= ext_nxt;
      len_r     <= len_nxt;
      len_hi_r  <= len_hi_nxt;
      key_r     <= key_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ----- rtl/wsfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// wsfr_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module wsfr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wsfr_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              busy,
  output wsfr_pkg::result_t out_res
);

  logic              valid_r;
  wsfr_pkg::result_t res_r;

  // a held result blocks new input only while the consumer stalls
  assign busy      = valid_r & out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/websocket_frame_receiver.sv -----
// A result appears on out_valid in the cycle after the byte's transfer.
// One byte per cycle while in_stall is low; header bytes update state, payload bytes
// take one XOR with the selected mask key byte.
// in_stall is high only while a result is held and out_stall is high.
// Reset (synchronous, rst_n low): parser expects a first header byte,
// max_payload returns to 4096, the output register is emptied.
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Byte-serial websocket frame deframer with payload unmasking.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wsfr_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wsfr_pkg::KIND_W-1:0]   out_kind,
  output logic [wsfr_pkg::BYTE_W-1:0]   out_data,
  output logic [wsfr_pkg::OPCODE_W-1:0] out_frame_opcode,
  output logic                          out_final_flag,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsfr_pkg::LEN_W-1:0]    cfg_max_payload
);

  logic [wsfr_pkg::LEN_W-1:0] max_payload_r;
  logic                       in_fire;
  logic                       res_valid;
  logic                       busy;
  wsfr_pkg::result_t          res;
  wsfr_pkg::result_t          out_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsfr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  wsfr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .rx_byte     (in_rx_byte),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire & res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_data         = out_res.data;
  assign out_frame_opcode = out_res.frame_opcode;
  assign out_final_flag   = out_res.final_flag;
  assign out_last         = out_res.last;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != wsfr_pkg::KIND_DATA) |-> (out_data == '0))
    else $error("non-data result carries data");

  a_nondata_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != wsfr_pkg::KIND_DATA) |-> out_last)
    else $error("non-data result without last");

  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall &&
     (out_kind == wsfr_pkg::KIND_CLOSE || out_kind == wsfr_pkg::KIND_ERROR))
    |=> !out_valid)
    else $error("result after close or length error");

endmodule

// ----- test/frame_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte, result and limit channels of the frame receiver, tracks
// the header parse and payload unmasking on its own, and compares every
// result transfer with the oldest result it predicted.
// ----------------------------------------------------------------------------
module frame_result_checker
  import wsfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [BYTE_W-1:0]   in_rx_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [KIND_W-1:0]   out_kind,
  input  logic [BYTE_W-1:0]   out_data,
  input  logic [OPCODE_W-1:0] out_frame_opcode,
  input  logic                out_final_flag,
  input  logic                out_last,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [LEN_W-1:0]    cfg_max_payload,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  typedef enum logic [2:0] {
    ST_HEAD0,
    ST_HEAD1,
    ST_EXTLEN,
    ST_KEY,
    ST_BODY
  } parse_state_e;

  parse_state_e        st;
  logic [OPCODE_W-1:0] op;
  logic                fin;
  logic                masked;
  logic [2:0]          ext_left;
  logic [63:0]         flen;
  logic [31:0]         key_word;
  logic [15:0]         idx;
  logic                halted;
  logic [LEN_W-1:0]    size_limit;

  result_t expected_results[$];
  result_t got;
  result_t want;
  int      mismatches   = 0;
  int      results_seen = 0;

  function automatic result_t make_result(input logic [KIND_W-1:0] kind,
                                          input logic [BYTE_W-1:0] data,
                                          input logic last);
    result_t r;
    r.kind         = kind;
    r.data         = data;
    r.frame_opcode = op;
    r.final_flag   = fin;
    r.last         = last;
    return r;
  endfunction

  // length and key are in: size check, then empty frame or payload
  function automatic bit finish_header(output result_t r);
    r = '0;
    if (flen > {48'd0, size_limit}) begin
      halted = 1'b1;
      r = make_result(KIND_ERROR, '0, 1'b1);
      return 1'b1;
    end
    if (flen == 64'd0) begin
      st = ST_HEAD0;
      r = make_result(KIND_EMPTY, '0, 1'b1);
      return 1'b1;
    end
    idx = '0;
    st  = ST_BODY;
    return 1'b0;
  endfunction

  function automatic bit length_known(output result_t r);
    r = '0;
    if (masked) begin
      idx = '0;
      st  = ST_KEY;
      return 1'b0;
    end
    return finish_header(r);
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
    logic [7:0] key;
    logic       last;
    r = '0;
    if (halted)
      return 1'b0;
    case (st)
      ST_HEAD0: begin
        fin      = b[7];
        op       = b[3:0];
        masked   = 1'b0;
        key_word = '0;
        flen     = '0;
        ext_left = '0;
        idx      = '0;
        st       = ST_HEAD1;
        return 1'b0;
      end
      ST_HEAD1: begin
        // close is reported before the length is even looked at
        if (op == OP_CLOSE) begin
          halted = 1'b1;
          r = make_result(KIND_CLOSE, '0, 1'b1);
          return 1'b1;
        end
        masked = b[7];
        if (b[6:0] == LEN_CODE_EXT16) begin
          ext_left = 3'd1;
          st       = ST_EXTLEN;
          return 1'b0;
        end
        if (b[6:0] == LEN_CODE_EXT64) begin
          ext_left = 3'd7;
          st       = ST_EXTLEN;
          return 1'b0;
        end
        flen = {57'd0, b[6:0]};
        return length_known(r);
      end
      ST_EXTLEN: begin
        flen = {flen[55:0], b};
        if (ext_left == 3'd0)
          return length_known(r);
        ext_left = ext_left - 3'd1;
        return 1'b0;
      end
      ST_KEY: begin
        key_word = {key_word[23:0], b};
        idx      = idx + 16'd1;
        if (idx >= 16'd4)
          return finish_header(r);
        return 1'b0;
      end
      ST_BODY: begin
        key  = key_word[8*(3-idx[1:0]) +: 8];
        last = ({48'd0, idx} + 64'd1 >= flen);
        idx  = idx + 16'd1;
        if (last)
          st = ST_HEAD0;
        r = make_result(KIND_DATA, b ^ key, last);
        return 1'b1;
      end
      default: begin
        st = ST_HEAD0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      st         = ST_HEAD0;
      op         = '0;
      fin        = 1'b0;
      masked     = 1'b0;
      ext_left   = '0;
      flen       = '0;
      key_word   = '0;
      idx        = '0;
      halted     = 1'b0;
      size_limit = MAX_PAYLOAD_RST;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_rx_byte, want))
          expected_results.insert(expected_results.size(), want);
      end
      if (out_valid && !out_stall) begin
        got.kind         = out_kind;
        got.data         = out_data;
        got.frame_opcode = out_frame_opcode;
        got.final_flag   = out_final_flag;
        got.last         = out_last;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d data %0d opcode %0d",
                 got.kind, got.data, got.frame_opcode);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("data", want.data, got.data);
          check_field("frame_opcode", want.frame_opcode, got.frame_opcode);
          check_field("final_flag", want.final_flag, got.final_flag);
          check_field("last", want.last, got.last);
        end
      end
      if (cfg_valid && cfg_ready)
        size_limit = cfg_max_payload;
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
    checked    <= results_seen;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds the frame receiver with well-formed frames of random content under a
// series of payload limits, with random gaps and output stalls, and ends the
// stream with a close frame or an oversize length.
// ----------------------------------------------------------------------------
module tb;
  import wsfr_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_CONT = 4'h0;
  localparam logic [OPCODE_W-1:0] OP_TEXT = 4'h1;
  localparam logic [OPCODE_W-1:0] OP_PING = 4'h9;
  localparam logic [OPCODE_W-1:0] OP_RSVD = 4'hF;
  localparam int TARGET_BYTES = 1550;

  typedef enum int {
    ENC_SHORT,
    ENC_EXT16,
    ENC_EXT64
  } len_enc_e;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_data;
  logic [OPCODE_W-1:0] out_frame_opcode;
  logic                out_final_flag;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_max_payload = '0;

  int fail_count;
  int pending;
  int checked;

  logic [LEN_W-1:0] cur_limit = MAX_PAYLOAD_RST;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int limits_set  = 0;
  bit end_with_close;

  websocket_frame_receiver uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data         (out_data),
    .out_frame_opcode (out_frame_opcode),
    .out_final_flag   (out_final_flag),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_payload  (cfg_max_payload)
  );

  frame_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data         (out_data),
    .out_frame_opcode (out_frame_opcode),
    .out_final_flag   (out_final_flag),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_payload  (cfg_max_payload),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure: short bursts mostly, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= gap_pct)
      return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // stop sending and let every predicted result come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LEN_W-1:0] v);
    drain();
    cfg_valid       <= 1'b1;
    cfg_max_payload <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
    limits_set++;
  endtask

  // payload goes out only when the length fits; otherwise the header is the test
  task automatic send_frame(input logic fin, input logic [2:0] rsv,
                            input logic [OPCODE_W-1:0] op, input logic masked,
                            input logic [31:0] key, input logic [63:0] len,
                            input len_enc_e enc, input bit edge_bytes);
    send_byte({fin, rsv, op});
    case (enc)
      ENC_SHORT: begin
        send_byte({masked, len[6:0]});
      end
      ENC_EXT16: begin
        send_byte({masked, LEN_CODE_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--)
          send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--)
        send_byte(key[8*i +: 8]);
    if (len <= {48'd0, cur_limit})
      for (longint unsigned i = 0; i < len; i++)
        send_byte(edge_bytes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
    frames_sent++;
  endtask

  task automatic random_frame();
    logic [OPCODE_W-1:0] op;
    int unsigned         lenmax;
    int unsigned         len;
    int unsigned         r;
    len_enc_e            enc;
    lenmax = (cur_limit < 300) ? cur_limit : 300;
    r = $urandom_range(0, 99);
    if (r < 10)
      len = 0;
    else if (r < 20)
      len = lenmax;
    else if (r < 85)
      len = $urandom_range(0, (lenmax < 20) ? lenmax : 20);
    else
      len = $urandom_range(0, lenmax);
    // any opcode but close, reserved ones included
    op = 4'($urandom_range(0, 14));
    if (op >= OP_CLOSE)
      op = op + 4'd1;
    r = $urandom_range(0, 99);
    if (len >= 126)
      enc = (r < 20) ? ENC_EXT64 : ENC_EXT16;
    else
      enc = (r < 75) ? ENC_SHORT : ((r < 90) ? ENC_EXT16 : ENC_EXT64);
    send_frame(1'($urandom), 3'($urandom), op, ($urandom_range(0, 99) < 60),
               $urandom, 64'(len), enc, 1'b0);
  endtask

  initial begin
    int phase;
    int phase_end;
    int waited;
    logic [LEN_W-1:0] v;
    logic [63:0] bad_len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short directed frames under the reset limit
    gap_pct   = 20;
    stall_pct = 20;
    send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 32'h0, 64'd0, ENC_SHORT, 1'b0);
    send_frame(1'b0, 3'b111, OP_CONT, 1'b0, 32'h0, 64'd2, ENC_SHORT, 1'b1);
    send_frame(1'b1, 3'b101, OP_PING, 1'b1, 32'hFF00_A55A, 64'd5, ENC_SHORT, 1'b0);
    send_frame(1'b0, 3'b000, OP_RSVD, 1'b0, 32'h0, 64'd1, ENC_EXT16, 1'b1);

    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      case (phase)
        0: v = 16'd0;
        1: v = 16'hFFFF;
        2: v = 16'($urandom_range(1, 24));
        default: begin
          case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(1, 30));
            1: v = 16'($urandom_range(31, 400));
            2: v = 16'($urandom);
            default: v = 16'hFFFF;
          endcase
        end
      endcase
      set_limit(v);
      case (phase % 3)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 30; stall_pct = 30; end
        default: begin gap_pct = 10; stall_pct = 60; end
      endcase
      phase_end = bytes_sent + ((v == 0) ? 40 : 200);
      while (bytes_sent < phase_end && bytes_sent < TARGET_BYTES)
        random_frame();
      phase++;
    end

    // one stop event per run; after it every byte is ignored
    drain();
    gap_pct        = 20;
    stall_pct      = 20;
    end_with_close = 1'($urandom);
    if (end_with_close) begin
      send_byte({1'($urandom), 3'($urandom), OP_CLOSE});
      send_byte(8'($urandom));
    end else begin
      if (cur_limit != 16'hFFFF && $urandom_range(0, 1) == 1) begin
        bad_len = {48'd0, cur_limit} + 64'd1;
        send_frame(1'($urandom), 3'($urandom), OP_TEXT, 1'($urandom), $urandom, bad_len,
                   (bad_len < 126) ? ENC_SHORT : ENC_EXT16, 1'b0);
      end else begin
        bad_len = {8'($urandom_range(1, 255)), 24'($urandom), 32'($urandom)};
        send_frame(1'($urandom), 3'($urandom), OP_PING, 1'($urandom), $urandom, bad_len,
                   ENC_EXT64, 1'b0);
      end
    end
    repeat (16) send_byte(8'($urandom));
    set_limit(16'($urandom));
    repeat (8) send_byte(8'($urandom));

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 5000);
    repeat (5) @(posedge clk);
    if (pending != 0)
      $error("%0d expected results never arrived", pending);

    $display("sent %0d frames, %0d bytes, under %0d payload limits; %0d results checked",
             frames_sent, bytes_sent, limits_set, checked);
    $display("stream ended with a %s and trailing ignored bytes",
             end_with_close ? "close frame" : "length error");
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
